/* hw/rtl/mwcc_pkg.sv */
// Shared constants, codes and widths of the multicast window credit controller.
package mwcc_pkg;

    // Sizing of the block.
    localparam int WINDOW_SLOTS      = 16;
    localparam int MAX_MEMBERS       = 16;
    localparam int MAX_MESSAGE_BYTES = 1024;

    // Derived address and count widths.
    localparam int SLOT_AW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
    localparam int MEM_AW  = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int EFF_W   = $clog2(MAX_MEMBERS + 1);

    // Fixed field widths.
    localparam int CMD_W      = 2;
    localparam int BYTES_W    = 16;
    localparam int MEMBER_W   = 4;
    localparam int COUNT_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 4;
    localparam int MCOUNT_W   = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEND    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_MEMBER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTHING    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MEMBER_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_MESSAGES = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [MCOUNT_W-1:0] MEMBER_COUNT_RESET   = 5'd2;
    localparam logic [COUNT_W-1:0]  TOTAL_MESSAGES_RESET = 32'd10;

endpackage

/* hw/rtl/multicast_window_credit_controller.sv */
// Top level of the multicast window credit controller.
//
// Requests arrive on the s_ channel (valid/ready) and each produces exactly one
// result on the m_ channel (valid/ready). An acquire reserves the next ring slot
// when fewer than WINDOW_SLOTS messages are outstanding past the finished count.
// A send bumps the generation of the next slot to send, and an ack stores one
// member's received count and rescans all members for the new finished count.
// The configuration port (cfg_we, cfg_index, cfg_data) must be written only while
// idle; the block itself does not enforce this.
// One request is processed at a time. An acquire goes straight to its result, a
// send first reads the generation memory, and an ack of a valid member first
// scans the effective members, reading the member memory one entry per cycle
// through its single read port. The next request is accepted in the cycle after
// the result is loaded. The result sits in an output register; when the receiver
// stalls, the next request is still accepted and worked on, and only its final
// step waits until the pending result is taken. Reset clears all counters, the
// valid bits of the member and generation memories, the done flag and the output
// valid bit, and restores member_count to 2 and total_messages to 10. No clearing
// pass is needed.
module multicast_window_credit_controller
    import mwcc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_command,
    input  logic [BYTES_W-1:0]    s_message_bytes,
    input  logic [MEMBER_W-1:0]   s_member_index,
    input  logic [COUNT_W-1:0]    s_received_count,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [SLOT_W-1:0]     m_slot_index,
    output logic [COUNT_W-1:0]    m_slot_generation,
    output logic [COUNT_W-1:0]    m_finished_count,
    output logic                  m_all_done
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_GEN    = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration.
    logic [MCOUNT_W-1:0] member_count_reg, member_count_next;
    logic [COUNT_W-1:0]  total_reg, total_next;

    // Window state.
    logic [COUNT_W-1:0]  queued_reg, queued_next;
    logic [COUNT_W-1:0]  sent_reg, sent_next;
    logic [COUNT_W-1:0]  finished_reg, finished_next;
    logic                done_reg, done_next;
    logic [SLOT_AW-1:0]  queued_slot_reg, queued_slot_next;
    logic [SLOT_AW-1:0]  sent_slot_reg, sent_slot_next;
    logic [WINDOW_SLOTS-1:0] gen_valid_reg, gen_valid_next;
    logic [MAX_MEMBERS-1:0]  mem_valid_reg, mem_valid_next;

    // Captured request.
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [MEMBER_W-1:0] member_reg, member_next;
    logic [COUNT_W-1:0]  received_reg, received_next;

    // Working registers.
    logic [COUNT_W-1:0]  gen_reg, gen_next;
    logic [COUNT_W-1:0]  min_reg, min_next;
    logic [EFF_W-1:0]    issue_idx_reg, issue_idx_next;
    logic [MEM_AW-1:0]   cmp_idx_reg, cmp_idx_next;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [SLOT_W-1:0]   m_slot_reg, m_slot_next;
    logic [COUNT_W-1:0]  m_gen_reg, m_gen_next;
    logic [COUNT_W-1:0]  m_finished_reg, m_finished_next;
    logic                m_done_reg, m_done_next;

    // Memory ports.
    logic                gen_we;
    logic [COUNT_W-1:0]  gen_rdata;
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr;
    logic [MEM_AW-1:0]   mem_raddr;
    logic [COUNT_W-1:0]  mem_rdata;

    logic [EFF_W-1:0]    eff_members;
    logic                bad_member;
    logic                out_free;
    logic                accept;
    logic [COUNT_W-1:0]  cmp_value;
    logic [COUNT_W-1:0]  gen_current;

    mwcc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (WINDOW_SLOTS)
    ) u_gen_ram (
        .aclk  (aclk),
        .we    (gen_we),
        .waddr (sent_slot_reg),
        .wdata (gen_reg),
        .raddr (sent_slot_reg),
        .rdata (gen_rdata)
    );

    mwcc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_MEMBERS)
    ) u_member_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (received_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // A member count of zero counts as one; above the maximum it saturates.
    always_comb begin
        if (member_count_reg == '0) begin
            eff_members = EFF_W'(1);
        end else if (32'(member_count_reg) > 32'(MAX_MEMBERS)) begin
            eff_members = EFF_W'(MAX_MEMBERS);
        end else begin
            eff_members = EFF_W'(member_count_reg);
        end
    end

    assign bad_member  = 32'(member_reg) >= 32'(eff_members);
    assign out_free    = !m_valid_reg || m_ready;
    assign accept      = s_valid && s_ready;
    assign s_ready     = (state_reg == S_IDLE);
    assign mem_waddr   = MEM_AW'(member_reg);
    assign mem_raddr   = issue_idx_reg[MEM_AW-1:0];
    assign gen_current = gen_valid_reg[sent_slot_reg] ? gen_rdata : '0;

    // The member being acknowledged is forwarded from the request, since its new
    // count is written only when the scan has finished.
    always_comb begin
        if (cmp_idx_reg == mem_waddr) begin
            cmp_value = received_reg;
        end else if (mem_valid_reg[cmp_idx_reg]) begin
            cmp_value = mem_rdata;
        end else begin
            cmp_value = '0;
        end
    end

    always_comb begin
        state_next        = state_reg;
        member_count_next = member_count_reg;
        total_next        = total_reg;
        queued_next       = queued_reg;
        sent_next         = sent_reg;
        finished_next     = finished_reg;
        done_next         = done_reg;
        queued_slot_next  = queued_slot_reg;
        sent_slot_next    = sent_slot_reg;
        gen_valid_next    = gen_valid_reg;
        mem_valid_next    = mem_valid_reg;
        cmd_next          = cmd_reg;
        bytes_next        = bytes_reg;
        member_next       = member_reg;
        received_next     = received_reg;
        gen_next          = gen_reg;
        min_next          = min_reg;
        issue_idx_next    = issue_idx_reg;
        cmp_idx_next      = cmp_idx_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_slot_next       = m_slot_reg;
        m_gen_next        = m_gen_reg;
        m_finished_next   = m_finished_reg;
        m_done_next       = m_done_reg;
        gen_we            = 1'b0;
        mem_we            = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                REG_MEMBER_COUNT:   member_count_next = cfg_data[MCOUNT_W-1:0];
                REG_TOTAL_MESSAGES: total_next        = cfg_data[COUNT_W-1:0];
                default:            ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next       = s_command;
                    bytes_next     = s_message_bytes;
                    member_next    = s_member_index;
                    received_next  = s_received_count;
                    issue_idx_next = '0;
                    if (s_command == CMD_SEND) begin
                        state_next = S_GEN;
                    end else if (s_command == CMD_ACK &&
                                 32'(s_member_index) < 32'(eff_members)) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_GEN: begin
                gen_next   = gen_current + COUNT_W'(1);
                state_next = S_FINISH;
            end
            S_SCAN: begin
                // Reads issue one member per cycle; each compare follows in the cycle after its read.
                if (issue_idx_reg != '0) begin
                    if (cmp_idx_reg == '0 || cmp_value < min_reg) begin
                        min_next = cmp_value;
                    end
                end
                if (issue_idx_reg == eff_members) begin
                    state_next = S_FINISH;
                end else begin
                    cmp_idx_next   = issue_idx_reg[MEM_AW-1:0];
                    issue_idx_next = issue_idx_reg + EFF_W'(1);
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_slot_next   = '0;
                    m_gen_next    = '0;
                    state_next    = S_IDLE;
                    case (cmd_reg)
                        CMD_ACQUIRE: begin
                            if (bytes_reg > BYTES_W'(MAX_MESSAGE_BYTES)) begin
                                m_status_next = ST_TOO_LARGE;
                            end else if ((queued_reg - finished_reg) <
                                         COUNT_W'(WINDOW_SLOTS)) begin
                                m_slot_next = SLOT_W'(queued_slot_reg);
                                queued_next = queued_reg + COUNT_W'(1);
                                if (queued_slot_reg == SLOT_AW'(WINDOW_SLOTS - 1)) begin
                                    queued_slot_next = '0;
                                end else begin
                                    queued_slot_next = queued_slot_reg + SLOT_AW'(1);
                                end
                            end else begin
                                m_status_next = ST_FULL;
                            end
                        end
                        CMD_SEND: begin
                            if (sent_reg == queued_reg) begin
                                m_status_next = ST_NOTHING;
                            end else begin
                                gen_we                        = 1'b1;
                                gen_valid_next[sent_slot_reg] = 1'b1;
                                m_slot_next                   = SLOT_W'(sent_slot_reg);
                                m_gen_next                    = gen_reg;
                                sent_next                     = sent_reg + COUNT_W'(1);
                                if (sent_slot_reg == SLOT_AW'(WINDOW_SLOTS - 1)) begin
                                    sent_slot_next = '0;
                                end else begin
                                    sent_slot_next = sent_slot_reg + SLOT_AW'(1);
                                end
                            end
                        end
                        CMD_ACK: begin
                            if (bad_member) begin
                                m_status_next = ST_BAD_MEMBER;
                            end else begin
                                mem_we                    = 1'b1;
                                mem_valid_next[mem_waddr] = 1'b1;
                                finished_next             = min_reg;
                                if (min_reg == total_reg) begin
                                    done_next = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                    m_finished_next = finished_next;
                    m_done_next     = done_next;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            member_count_reg <= MEMBER_COUNT_RESET;
            total_reg        <= TOTAL_MESSAGES_RESET;
            queued_reg       <= '0;
            sent_reg         <= '0;
            finished_reg     <= '0;
            done_reg         <= 1'b0;
            queued_slot_reg  <= '0;
            sent_slot_reg    <= '0;
            gen_valid_reg    <= '0;
            mem_valid_reg    <= '0;
            issue_idx_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            member_count_reg <= member_count_next;
            total_reg        <= total_next;
            queued_reg       <= queued_next;
            sent_reg         <= sent_next;
            finished_reg     <= finished_next;
            done_reg         <= done_next;
            queued_slot_reg  <= queued_slot_next;
            sent_slot_reg    <= sent_slot_next;
            gen_valid_reg    <= gen_valid_next;
            mem_valid_reg    <= mem_valid_next;
            issue_idx_reg    <= issue_idx_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        bytes_reg      <= bytes_next;
        member_reg     <= member_next;
        received_reg   <= received_next;
        gen_reg        <= gen_next;
        min_reg        <= min_next;
        cmp_idx_reg    <= cmp_idx_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_gen_reg      <= m_gen_next;
        m_finished_reg <= m_finished_next;
        m_done_reg     <= m_done_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_slot_index      = m_slot_reg;
    assign m_slot_generation = m_gen_reg;
    assign m_finished_count  = m_finished_reg;
    assign m_all_done        = m_done_reg;

endmodule

/* hw/rtl/mwcc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module mwcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/mwcc_checker.sv */
// Port-level checker for the multicast window credit controller, with its bind.
module mwcc_checker
    import mwcc_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [SLOT_W-1:0]   m_slot_index,
    input logic [COUNT_W-1:0]  m_slot_generation,
    input logic                m_all_done
);

    logic done_seen_reg;

    // Remembers that a delivered result has already reported the run as done.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_seen_reg <= 1'b0;
        end else if (m_valid && m_ready && m_all_done) begin
            done_seen_reg <= 1'b1;
        end
    end

    // Only one request is in flight, so ready drops right after an acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another one is in progress");

    // The done flag never clears once it has been reported.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && done_seen_reg |-> m_all_done)
        else $error("done flag cleared after it was reported");

    // A rejected request names no slot and no generation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_slot_index == '0 && m_slot_generation == '0)
        else $error("rejected request carries slot information");

    // Every delivered result carries one of the defined status codes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_NOTHING)
        else $error("undefined status code");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_slot_index) && $stable(m_slot_generation))
        else $error("stalled result changed");

endmodule

bind multicast_window_credit_controller mwcc_checker u_mwcc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_slot_index      (m_slot_index),
    .m_slot_generation (m_slot_generation),
    .m_all_done        (m_all_done)
);
